@@ hdl/arrow_rule_line_tagger_assert.svh @@
// assertion macros shared by the arrow rule line tagger modules
`ifndef ARROW_RULE_LINE_TAGGER_ASSERT_SVH
`define ARROW_RULE_LINE_TAGGER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ARLT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arlt assertion failed");
`define ARLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arlt assertion failed");
`else
`define ARLT_ASSERT_SAME(lbl, ante, cons)
`define ARLT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/arlt_pkg.sv @@
// shared types, codes and constants of the arrow rule line tagger
package arlt_pkg;

    localparam logic [2:0] KIND_SEL   = 3'd0;
    localparam logic [2:0] KIND_PATH  = 3'd1;
    localparam logic [2:0] KIND_ARROW = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_NO_SELECTOR  = 2'd1;
    localparam logic [1:0] ERR_NO_PATH      = 2'd2;
    localparam logic [1:0] ERR_ARROW_IN_PATH = 2'd3;

    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [1:0] SEL_LEN_MAX   = 2'd3;
    localparam logic [1:0] SEL_LEN_EMPTY = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int TDATA_W     = 80;
    localparam int PAYLOAD_W   = 74;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  text_byte;
        logic [1:0]  error_code;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic [31:0] byte_position;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

endpackage

@@ hdl/arrow_rule_line_tagger.sv @@
// top level of the arrow rule line tagger: byte stream in, tagged beats out
// each result is written into the result queue as its input beat is taken
// throughput: one input beat per cycle while s_tready is high; a byte with a held dash gives two
// output beats, which the four-entry result queue absorbs
// reset: rst_n clears the parse mode, counters, sticky error and the queue
module arrow_rule_line_tagger #(
    parameter int QUEUE_DEPTH = arlt_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // ch
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // text_byte, error_code, line_number, column_number, byte_position, zero fill
    output logic [arlt_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]                   m_tuser,  // kind
    output logic                         m_tlast
);
    import arlt_pkg::*;

    push_t   push;
    result_t head;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    arlt_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (s_tdata),
        .push   (push)
    );

    arlt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata = {(TDATA_W - PAYLOAD_W)'(0), head.byte_position, head.column_number,
                      head.line_number, head.error_code, head.text_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

@@ hdl/arlt_parser.sv @@
// parse mode machine, position counters and result generation per byte
`include "arrow_rule_line_tagger_assert.svh"

module arlt_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       ch,
    output arlt_pkg::push_t  push
);
    import arlt_pkg::*;

    localparam logic [1:0] MODE_EXPECT   = 2'd0;
    localparam logic [1:0] MODE_SELECTOR = 2'd1;
    localparam logic [1:0] MODE_PATH     = 2'd2;

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  prev_reg, prev_next;
    logic        held_reg, held_next;
    logic [1:0]  len_reg, len_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic [31:0] pos_reg, pos_next;
    logic        error_reg, error_next;

    logic        arrow;
    logic        start;
    logic        held_base;
    logic [1:0]  len_base;
    logic        emit_dash;
    logic        emit_main;
    logic [2:0]  main_kind;
    logic [7:0]  main_text;
    logic [1:0]  main_code;
    result_t     dash_res;
    result_t     main_res;

    assign arrow     = (prev_reg == CH_DASH) && (ch == CH_GT);
    assign start     = (mode_reg != MODE_SELECTOR);
    assign held_base = start ? 1'b0 : held_reg;
    assign len_base  = start ? 2'd0 : len_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        held_next  = held_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        error_next = error_reg;
        emit_dash  = 1'b0;
        emit_main  = 1'b0;
        main_kind  = KIND_SEL;
        main_text  = 8'd0;
        main_code  = ERR_NONE;
        if (accept && !error_reg)
        begin
            col_next  = (col_reg == 16'hFFFF) ? col_reg : col_reg + 16'd1;
            pos_next  = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;
            prev_next = ch;
            if (mode_reg == MODE_PATH)
            begin
                emit_main = 1'b1;
                if (ch == CH_NL)
                begin
                    line_next = (line_reg == 16'hFFFF) ? line_reg : line_reg + 16'd1;
                    col_next  = 16'd0;
                    mode_next = MODE_EXPECT;
                    main_kind = KIND_END;
                end
                else if (arrow)
                begin
                    error_next = 1'b1;
                    main_kind  = KIND_ERR;
                    main_code  = ERR_ARROW_IN_PATH;
                end
                else
                begin
                    main_kind = KIND_PATH;
                    main_text = ch;
                end
            end
            else if (!(start && is_space(ch)))
            begin
                mode_next = MODE_SELECTOR;
                len_next  = (len_base == SEL_LEN_MAX) ? len_base : len_base + 2'd1;
                if (arrow)
                begin
                    held_next = 1'b0;
                    emit_main = 1'b1;
                    if (len_next == SEL_LEN_EMPTY)
                    begin
                        error_next = 1'b1;
                        main_kind  = KIND_ERR;
                        main_code  = ERR_NO_SELECTOR;
                    end
                    else
                    begin
                        mode_next = MODE_PATH;
                        main_kind = KIND_ARROW;
                    end
                end
                else if (ch == CH_NL)
                begin
                    error_next = 1'b1;
                    held_next  = 1'b0;
                    emit_main  = 1'b1;
                    main_kind  = KIND_ERR;
                    main_code  = ERR_NO_PATH;
                end
                else
                begin
                    emit_dash = held_base;
                    if (ch == CH_DASH)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        held_next = 1'b0;
                        emit_main = 1'b1;
                        main_kind = KIND_SEL;
                        main_text = ch;
                    end
                end
            end
        end
    end

    always_comb
    begin
        dash_res.kind          = KIND_SEL;
        dash_res.text_byte     = CH_DASH;
        dash_res.error_code    = ERR_NONE;
        dash_res.line_number   = line_next;
        dash_res.column_number = col_next;
        dash_res.byte_position = pos_next;
        dash_res.last          = !emit_main;

        main_res.kind          = main_kind;
        main_res.text_byte     = main_text;
        main_res.error_code    = main_code;
        main_res.line_number   = line_next;
        main_res.column_number = col_next;
        main_res.byte_position = pos_next;
        main_res.last          = 1'b1;

        push.count  = {1'b0, emit_dash} + {1'b0, emit_main};
        push.first  = emit_dash ? dash_res : main_res;
        push.second = main_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_EXPECT;
            prev_reg  <= 8'd0;
            held_reg  <= 1'b0;
            len_reg   <= 2'd0;
            line_reg  <= 16'd0;
            col_reg   <= 16'd0;
            pos_reg   <= 32'd0;
            error_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            held_reg  <= held_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            error_reg <= error_next;
        end
    end

    `ARLT_ASSERT_NEXT(a_error_sticky, error_reg, error_reg)
    `ARLT_ASSERT_SAME(a_no_result_after_error, error_reg, push.count == 2'd0)
    `ARLT_ASSERT_SAME(a_pair_starts_with_dash, push.count == 2'd2,
        push.first.text_byte == CH_DASH && push.first.kind == KIND_SEL)

endmodule

@@ hdl/arlt_queue.sv @@
// small result queue taking up to two results a cycle and giving one while out_ready is high
`include "arrow_rule_line_tagger_assert.svh"

module arlt_queue #(
    parameter int DEPTH = arlt_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  arlt_pkg::push_t   push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output arlt_pkg::result_t out_res
);
    import arlt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    result_t           store [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_second;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = store[rd_reg];
    assign space_ok  = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_second = ptr_inc(wr_reg);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = pop ? ptr_inc(rd_reg) : rd_reg;
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
        case (push.count)
            2'd1:    wr_next = wr_second;
            2'd2:    wr_next = ptr_inc(wr_second);
            default: wr_next = wr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            store[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            store[wr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `ARLT_ASSERT_SAME(a_push_has_room, push.count != 2'd0, space_ok)
    `ARLT_ASSERT_NEXT(a_pop_only_drains, pop && push.count == 2'd0,
        count_reg == $past(count_reg) - CNT_W'(1))
    `ARLT_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

@@ tb/sv/tb_arrow_rule_line_tagger.sv @@
// self-checking testbench of the arrow rule line tagger: directed table, random rules, sticky error
module tb_arrow_rule_line_tagger;
    timeunit 1ns;
    timeprecision 1ps;

    import arlt_pkg::*;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int MAX_GAP        = 18;
    localparam int HOLD_CYCLES    = 150;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int N_DIRECTED     = 26;

    typedef enum logic [1:0] {
        EXPECTING,
        GETTING_SEL,
        IN_PATH
    } mode_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [2:0] kind;
        logic [7:0] text;
        logic [1:0] code;
    } stim_t;

    localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

    localparam stim_t DIRECTED [N_DIRECTED] = '{
        '{CH_SPACE, 1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_NL,    1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{8'h00,    1'b1, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_DASH,  1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_DASH,  1'b1, KIND_SEL,   CH_DASH,  ERR_NONE},
        '{8'h62,    1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_DASH,  1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_GT,    1'b1, KIND_ARROW, 8'h00,    ERR_NONE},
        '{8'hFF,    1'b1, KIND_PATH,  8'hFF,    ERR_NONE},
        '{CH_DASH,  1'b1, KIND_PATH,  CH_DASH,  ERR_NONE},
        '{CH_SPACE, 1'b1, KIND_PATH,  CH_SPACE, ERR_NONE},
        '{CH_NL,    1'b1, KIND_END,   8'h00,    ERR_NONE},
        '{CH_TAB,   1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_CR,    1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_VT,    1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_FF,    1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_DASH,  1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_DASH,  1'b1, KIND_SEL,   CH_DASH,  ERR_NONE},
        '{CH_GT,    1'b1, KIND_ARROW, 8'h00,    ERR_NONE},
        '{CH_GT,    1'b1, KIND_PATH,  CH_GT,    ERR_NONE},
        '{CH_NL,    1'b1, KIND_END,   8'h00,    ERR_NONE},
        '{8'h61,    1'b1, KIND_SEL,   8'h61,    ERR_NONE},
        '{CH_SPACE, 1'b1, KIND_SEL,   CH_SPACE, ERR_NONE},
        '{CH_DASH,  1'b0, KIND_SEL,   8'h00,    ERR_NONE},
        '{CH_GT,    1'b1, KIND_ARROW, 8'h00,    ERR_NONE},
        '{CH_NL,    1'b1, KIND_END,   8'h00,    ERR_NONE}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [2:0]          m_tuser;
    logic                m_tlast;

    // parser state mirrored by the predictor
    mode_e       mode;
    logic [7:0]  prev_ch;
    logic        dash_held;
    logic [1:0]  sel_len;
    logic [15:0] line_cnt;
    logic [15:0] col_cnt;
    logic [31:0] pos_cnt;
    logic        err_sticky;

    result_t pending_tags [$];
    int      mismatches;
    int      idle_cycles;
    int      rand_items;
    bit      idle_on;
    bit      hold_req;

    arrow_rule_line_tagger dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bit is_blank(input logic [7:0] ch);
        return ch inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [7:0] text,
                                 input logic [1:0] code);
        result_t r;
        r = '{kind, text, code, line_cnt, col_cnt, pos_cnt, 1'b0};
        pending_tags.push_back(r);
    endfunction

    function automatic int tag_byte(input logic [7:0] ch);
        logic    arrow;
        int      n;
        result_t r;
        arrow = (prev_ch == CH_DASH) && (ch == CH_GT);
        n = 0;
        if (err_sticky)
            return 0;
        if (col_cnt != 16'hFFFF)
            col_cnt++;
        if (pos_cnt != 32'hFFFF_FFFF)
            pos_cnt++;
        prev_ch = ch;
        if (mode == IN_PATH)
        begin
            n = 1;
            if (ch == CH_NL)
            begin
                if (line_cnt != 16'hFFFF)
                    line_cnt++;
                col_cnt = 16'h0000;
                mode = EXPECTING;
                emit(KIND_END, 8'h00, ERR_NONE);
            end
            else if (arrow)
            begin
                err_sticky = 1'b1;
                emit(KIND_ERR, 8'h00, ERR_ARROW_IN_PATH);
            end
            else
            begin
                emit(KIND_PATH, ch, ERR_NONE);
            end
        end
        else
        begin
            if (mode != GETTING_SEL)
            begin
                if (is_blank(ch))
                    return 0;
                mode = GETTING_SEL;
                sel_len = 2'd0;
                dash_held = 1'b0;
            end
            if (sel_len < SEL_LEN_MAX)
                sel_len++;
            if (arrow)
            begin
                n = 1;
                dash_held = 1'b0;
                if (sel_len == SEL_LEN_EMPTY)
                begin
                    err_sticky = 1'b1;
                    emit(KIND_ERR, 8'h00, ERR_NO_SELECTOR);
                end
                else
                begin
                    mode = IN_PATH;
                    emit(KIND_ARROW, 8'h00, ERR_NONE);
                end
            end
            else if (ch == CH_NL)
            begin
                n = 1;
                err_sticky = 1'b1;
                dash_held = 1'b0;
                emit(KIND_ERR, 8'h00, ERR_NO_PATH);
            end
            else
            begin
                // a held dash is released ahead of the byte that follows it
                if (dash_held)
                begin
                    emit(KIND_SEL, CH_DASH, ERR_NONE);
                    n++;
                end
                if (ch == CH_DASH)
                begin
                    dash_held = 1'b1;
                end
                else
                begin
                    dash_held = 1'b0;
                    emit(KIND_SEL, ch, ERR_NONE);
                    n++;
                end
            end
        end
        if (n > 0)
        begin
            r = pending_tags.pop_back();
            r.last = 1'b1;
            pending_tags.push_back(r);
        end
        return n;
    endfunction

    function automatic int draw_gap();
        if (!idle_on || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic stim_t plain(input logic [7:0] ch);
        return '{ch, 1'b0, KIND_SEL, 8'h00, ERR_NONE};
    endfunction

    function automatic logic [7:0] pick_text(input bit no_blank);
        logic [7:0] c;
        do
        begin
            case ($urandom_range(0, 7))
                0:       c = CH_DASH;
                1:       c = CH_GT;
                2:       c = BLANKS[$urandom_range(0, 5)];
                default: c = 8'($urandom_range(0, 255));
            endcase
        end
        while (c == CH_NL || (prev_ch == CH_DASH && c == CH_GT) || (no_blank && is_blank(c)));
        return c;
    endfunction

    task automatic send_byte(input stim_t s);
        int      g;
        int      n;
        result_t r;
        g = draw_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s.ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = tag_byte(s.ch);
        if (s.typed && n > 0)
        begin
            r = pending_tags.pop_back();
            r.kind       = s.kind;
            r.text_byte  = s.text;
            r.error_code = s.code;
            pending_tags.push_back(r);
        end
    endtask

    task automatic send_rule(input int n_sel, input int n_path, input bit noisy);
        int i;
        if (noisy && $urandom_range(0, 3) == 0)
        begin
            for (i = $urandom_range(1, 4); i > 0; i--)
                send_byte(plain(BLANKS[$urandom_range(0, 5)]));
        end
        send_byte(plain(pick_text(1'b1)));
        for (i = 1; i < n_sel; i++)
            send_byte(plain(pick_text(1'b0)));
        send_byte(plain(CH_DASH));
        send_byte(plain(CH_GT));
        for (i = 0; i < n_path; i++)
            send_byte(plain(pick_text(1'b0)));
        send_byte(plain(CH_NL));
        rand_items += n_sel + n_path + 3;
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // output monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tags.size() == 0)
            begin
                $error("unexpected result beat: kind %0d, tdata %0h", m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_tags.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("text_byte", want.text_byte, m_tdata[7:0]);
                check_field("error_code", want.error_code, m_tdata[9:8]);
                check_field("line_number", want.line_number, m_tdata[25:10]);
                check_field("column_number", want.column_number, m_tdata[41:26]);
                check_field("byte_position", want.byte_position, m_tdata[73:42]);
                check_field("last", want.last, m_tlast);
                check_field("zero fill", 0, m_tdata[TDATA_W-1:74]);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result sink
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (hold_req && !held)
                begin
                    g = HOLD_CYCLES;
                    held = 1'b1;
                end
                else
                begin
                    g = draw_gap();
                end
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        int  i;
        int  code;
        bit  hold_done;
        bit  pause_done;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        mode        = EXPECTING;
        prev_ch     = 8'h00;
        dash_held   = 1'b0;
        sel_len     = 2'd0;
        line_cnt    = 16'h0000;
        col_cnt     = 16'h0000;
        pos_cnt     = 32'h0000_0000;
        err_sticky  = 1'b0;
        rand_items  = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i]);

        while (rand_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                idle_on = !idle_on;
            if (!hold_done && rand_items >= RANDOM_ITEMS / 3)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && rand_items >= 2 * RANDOM_ITEMS / 3)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_tags.size() != 0)
                    @(posedge clk);
                pause_done = 1'b1;
            end
            send_rule(($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10),
                      1'b1);
        end

        idle_on = 1'b1;
        for (i = 0; i < 3; i++)
            send_rule($urandom_range(1, 6), $urandom_range(0, 8), 1'b1);

        // one sticky error ends the parse
        if (mode == GETTING_SEL)
        begin
            send_byte(plain(8'h78));
            send_byte(plain(CH_DASH));
            send_byte(plain(CH_GT));
        end
        if (mode == IN_PATH)
            send_byte(plain(CH_NL));
        code = $urandom_range(1, 3);
        case (code)
            1:
            begin
                send_byte(plain(CH_DASH));
                send_byte('{CH_GT, 1'b1, KIND_ERR, 8'h00, ERR_NO_SELECTOR});
            end
            2:
            begin
                send_byte(plain(8'h61));
                send_byte('{CH_NL, 1'b1, KIND_ERR, 8'h00, ERR_NO_PATH});
            end
            default:
            begin
                send_byte(plain(8'h61));
                send_byte(plain(CH_DASH));
                send_byte(plain(CH_GT));
                send_byte(plain(CH_DASH));
                send_byte('{CH_GT, 1'b1, KIND_ERR, 8'h00, ERR_ARROW_IN_PATH});
            end
        endcase
        for (i = 0; i < 8; i++)
            send_byte(plain(8'($urandom_range(0, 255))));
        s_tvalid <= 1'b0;

        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
